@@ rtl/shfd_pkg.sv @@
package shfd_pkg;

  // Sync characters and token of the frame header
  localparam logic [7:0] SYNC_U   = 8'h55;
  localparam logic [7:0] SYNC_N   = 8'h4E;
  localparam logic [7:0] SYNC_E   = 8'h45;
  localparam logic [7:0] SYNC_R   = 8'h52;
  localparam logic [7:0] TOKEN_CH = 8'h3A;

  // Fixed part of the checksum: XOR of the four sync characters and the token
  localparam logic [7:0] HDR_XOR = SYNC_U ^ SYNC_N ^ SYNC_E ^ SYNC_R ^ TOKEN_CH;

  // Smallest legal length byte (command id plus checksum)
  localparam logic [7:0] MIN_LEN = 8'd2;

  // Event codes of a result word
  localparam logic [1:0] EV_PAYLOAD  = 2'd0;
  localparam logic [1:0] EV_ACCEPTED = 2'd1;
  localparam logic [1:0] EV_MISMATCH = 2'd2;
  localparam logic [1:0] EV_BAD_LEN  = 2'd3;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] data_byte;
    logic [7:0] cmd_id;
    logic [7:0] payload_index;
    logic [7:0] frame_length;
    logic       frame_end;
  } res_t;

endpackage

@@ rtl/shfd_if.sv @@
interface shfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface shfd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] data_byte;
  logic [7:0] cmd_id;
  logic [7:0] payload_index;
  logic [7:0] frame_length;
  logic       frame_end;

  modport source (output valid, output event_res, output data_byte, output cmd_id,
                  output payload_index, output frame_length, output frame_end,
                  input ready);
  modport sink   (input valid, input event_res, input data_byte, input cmd_id,
                  input payload_index, input frame_length, input frame_end,
                  output ready);
endinterface

@@ rtl/sync_header_frame_decoder_top.sv @@
// Frame decoder for a received byte stream.
// in_ch carries one received byte per word (valid/ready). The decoder hunts
// for the header "UNER", a length byte, ':' and a command id, then passes on
// length-2 payload bytes and checks the trailing XOR checksum byte.
// out_ch carries at most one result word per input word: a payload byte with
// its index, or a frame end event (accepted, checksum mismatch, bad length).
// Header bytes other than a bad length byte and sync hunting produce no result word.
// A byte accepted on in_ch goes into the input register and is then decoded
// into the result register.
// Throughput: one byte per cycle while the skid register is empty; the decode is
// one state update, one compare and one XOR between input and result register.
// A two-word result buffer (output register plus skid register) lets the
// decoder take further bytes while one result waits; once both are full the
// input register holds its byte and in_ch.ready drops until out_ch.ready.
// Reset (rst_n low, synchronous) empties both stages, returns the decoder to
// hunting for 'U' and clears the held length, id, checksum and counters.
module sync_header_frame_decoder_top (
  input  logic              clk,
  input  logic              rst_n,
  shfd_in_if.sink           in_ch,
  shfd_out_if.source        out_ch
);
  import shfd_pkg::*;

  typedef enum logic [2:0] {
    ST_U, ST_N, ST_E, ST_R, ST_LEN, ST_TOK, ST_ID, ST_BODY
  } pst_t;

  pst_t       state_r, state_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] id_r, id_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] cnt_r, cnt_nxt;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] byte_r;
  logic       main_valid_r, main_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  res_t       main_r, main_nxt;
  res_t       skid_r, skid_nxt;

  logic       fire;
  logic       pop;
  logic       res_vld;
  res_t       res;
  pst_t       rehunt;

  // Decode the held byte when the skid register has room
  assign fire = s1_valid_r && !skid_valid_r;
  assign pop  = main_valid_r && out_ch.ready;
  assign in_ch.ready = !s1_valid_r || fire;

  assign rehunt = (byte_r == SYNC_U) ? ST_N : ST_U;

  // Parse one byte: next state and optional result word
  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    id_nxt    = id_r;
    xor_nxt   = xor_r;
    left_nxt  = left_r;
    cnt_nxt   = cnt_r;
    res_vld   = 1'b0;
    res       = '0;
    if (fire) begin
      unique case (state_r)
        ST_U: state_nxt = (byte_r == SYNC_U) ? ST_N : ST_U;
        ST_N: state_nxt = (byte_r == SYNC_N) ? ST_E : rehunt;
        ST_E: state_nxt = (byte_r == SYNC_E) ? ST_R : rehunt;
        ST_R: state_nxt = (byte_r == SYNC_R) ? ST_LEN : rehunt;
        ST_LEN: begin
          len_nxt = byte_r;
          if (byte_r < MIN_LEN) begin
            state_nxt          = ST_U;
            res_vld            = 1'b1;
            res.event_res      = EV_BAD_LEN;
            res.frame_length   = byte_r;
            res.frame_end      = 1'b1;
          end else begin
            state_nxt = ST_TOK;
          end
        end
        ST_TOK: state_nxt = (byte_r == TOKEN_CH) ? ST_ID : rehunt;
        ST_ID: begin
          id_nxt    = byte_r;
          xor_nxt   = HDR_XOR ^ len_r ^ byte_r;
          left_nxt  = len_r - MIN_LEN;
          cnt_nxt   = '0;
          state_nxt = ST_BODY;
        end
        ST_BODY: begin
          res_vld          = 1'b1;
          res.data_byte    = byte_r;
          res.cmd_id       = id_r;
          res.frame_length = len_r;
          if (left_r != '0) begin
            res.event_res     = EV_PAYLOAD;
            res.payload_index = cnt_r;
            xor_nxt           = xor_r ^ byte_r;
            left_nxt          = left_r - 8'd1;
            cnt_nxt           = cnt_r + 8'd1;
          end else begin
            res.frame_end = 1'b1;
            if (byte_r == xor_r) begin
              res.event_res = EV_ACCEPTED;
              state_nxt     = ST_U;
            end else begin
              res.event_res = EV_MISMATCH;
              state_nxt     = rehunt;
            end
          end
        end
      endcase
    end
  end

  // Advance the input stage and the two-word result buffer
  always_comb begin
    s1_valid_nxt   = in_ch.ready ? in_ch.valid : s1_valid_r;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = res;
        main_valid_nxt = res_vld;
      end
    end else if (!main_valid_r) begin
      main_nxt       = res;
      main_valid_nxt = res_vld;
    end else if (res_vld) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  // Hold parse state, control flags and the registered result words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_U;
      len_r        <= '0;
      id_r         <= '0;
      xor_r        <= '0;
      left_r       <= '0;
      cnt_r        <= '0;
      s1_valid_r   <= 1'b0;
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      id_r         <= id_nxt;
      xor_r        <= xor_nxt;
      left_r       <= left_nxt;
      cnt_r        <= cnt_nxt;
      s1_valid_r   <= s1_valid_nxt;
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.rx_byte;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid         = main_valid_r;
  assign out_ch.event_res     = main_r.event_res;
  assign out_ch.data_byte     = main_r.data_byte;
  assign out_ch.cmd_id        = main_r.cmd_id;
  assign out_ch.payload_index = main_r.payload_index;
  assign out_ch.frame_length  = main_r.frame_length;
  assign out_ch.frame_end     = main_r.frame_end;

endmodule

@@ rtl/shfd_checker.sv @@
module shfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event_res,
  input logic [7:0] out_data_byte,
  input logic [7:0] out_cmd_id,
  input logic [7:0] out_payload_index,
  input logic [7:0] out_frame_length,
  input logic       out_frame_end
);
  import shfd_pkg::*;

  // Drop the result channel during and right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown after reset");

  // Hold a stalled result word
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res) &&
      $stable(out_data_byte) && $stable(out_cmd_id) && $stable(out_payload_index) &&
      $stable(out_frame_length) && $stable(out_frame_end))
    else $error("stalled result word changed");

  // Mark every frame end event and only those as last word, with index zero
  a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_end == (out_event_res != EV_PAYLOAD)) &&
      (!out_frame_end || out_payload_index == 8'd0))
    else $error("frame end flag disagrees with event");

  // Bad length carries a short length and no id or data
  a_bad_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_BAD_LEN |->
      out_frame_length < MIN_LEN && out_data_byte == 8'd0 && out_cmd_id == 8'd0)
    else $error("bad length word malformed");

  // Keep payload index inside the declared payload
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_PAYLOAD |->
      ({1'b0, out_payload_index} + 9'd2) < {1'b0, out_frame_length})
    else $error("payload index beyond frame length");

endmodule

bind sync_header_frame_decoder_top shfd_checker u_shfd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_event_res     (out_ch.event_res),
  .out_data_byte     (out_ch.data_byte),
  .out_cmd_id        (out_ch.cmd_id),
  .out_payload_index (out_ch.payload_index),
  .out_frame_length  (out_ch.frame_length),
  .out_frame_end     (out_ch.frame_end)
);
